// ----- rtl/rsd_pkg.sv -----
`default_nettype none

package rsd_pkg;

	localparam int MAX_DEPTH = 16;
	localparam int LEN_BITS  = 32;
	// a length field wider than 32 bits cannot be carried
	localparam int LBITS     = (LEN_BITS < 32) ? LEN_BITS : 32;
	localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W     = $clog2(MAX_DEPTH);

	localparam logic [7:0] STR_BASE  = 8'h80;
	localparam logic [7:0] LIST_BASE = 8'hC0;
	localparam int         LONG_OFS  = 55;
	localparam logic [7:0] STR_LONG  = 8'(int'(STR_BASE) + LONG_OFS);
	localparam logic [7:0] LIST_LONG = 8'(int'(LIST_BASE) + LONG_OFS);

	typedef enum logic [2:0] {
		KIND_HEADER     = 3'd0,
		KIND_SINGLE     = 3'd1,
		KIND_STR_START  = 3'd2,
		KIND_DATA       = 3'd3,
		KIND_LIST_START = 3'd4,
		KIND_LIST_END   = 3'd5,
		KIND_IGNORED    = 3'd6,
		KIND_ERROR      = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_TRUNC   = 3'd1,
		ERR_OVERRUN = 3'd2,
		ERR_DEEP    = 3'd3,
		ERR_LENGTH  = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		CLS_SINGLE,
		CLS_SHORT_STR,
		CLS_LONG_STR,
		CLS_SHORT_LIST,
		CLS_LONG_LIST
	} cls_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [31:0] item_length;
		logic [4:0]  depth;
		err_t        error_code;
		logic        last_of_run;
		logic        item_done;
	} token_t;

	// classified byte as it waits between front and back
	typedef struct packed {
		byte_item_t item;
		cls_t       cls;
		logic [5:0] short_len;
		logic [3:0] len_bytes;
	} entry_t;

endpackage

`default_nettype wire

// ----- rtl/rsd_front.sv -----
`default_nettype none

module rsd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  rsd_pkg::byte_item_t byte_data,
	output logic               head_valid,
	output rsd_pkg::entry_t    head,
	input  logic               head_pop
);
	import rsd_pkg::*;

	entry_t     cls_entry;
	entry_t     q_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	always_comb begin
		cls_entry           = '0;
		cls_entry.item      = byte_data;
		if (byte_data.byte_in < STR_BASE) begin
			cls_entry.cls = CLS_SINGLE;
		end else if (byte_data.byte_in <= STR_LONG) begin
			cls_entry.cls       = CLS_SHORT_STR;
			cls_entry.short_len = 6'(byte_data.byte_in - STR_BASE);
		end else if (byte_data.byte_in < LIST_BASE) begin
			cls_entry.cls       = CLS_LONG_STR;
			cls_entry.len_bytes = 4'(byte_data.byte_in - STR_LONG);
		end else if (byte_data.byte_in <= LIST_LONG) begin
			cls_entry.cls       = CLS_SHORT_LIST;
			cls_entry.short_len = 6'(byte_data.byte_in - LIST_BASE);
		end else begin
			cls_entry.cls       = CLS_LONG_LIST;
			cls_entry.len_bytes = 4'(byte_data.byte_in - LIST_LONG);
		end
	end

	assign byte_stall = (cnt_q == 2'd2);
	assign push       = byte_valid && !byte_stall;
	assign head_valid = (cnt_q != 2'd0);
	assign pop        = head_pop && head_valid;
	assign head       = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= cls_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rsd_back.sv -----
`default_nettype none

module rsd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  rsd_pkg::entry_t head,
	output logic            head_pop,
	output logic            token_valid,
	input  logic            token_stall,
	output rsd_pkg::token_t token
);
	import rsd_pkg::*;

	typedef enum logic [2:0] {
		S_MAIN,
		S_LOOK,
		S_CLOSE,
		S_ERR,
		S_TRUNC
	} seq_t;

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_LENB,
		PH_DATA,
		PH_DONE,
		PH_FAIL
	} phase_t;

	seq_t             state_q, state_d;
	phase_t           phase_q, phase_d;
	err_t             code_q, code_d;
	logic [3:0]       left_q, left_d;
	logic [31:0]      acc_q, acc_d;
	logic             is_list_q, is_list_d;
	logic [32:0]      nxt_q, nxt_d;
	logic [32:0]      end_pos_q, end_pos_d;
	logic [31:0]      str_end_q, str_end_d;
	logic [CNT_W-1:0] open_q, open_d;
	logic [31:0]      stack_q [MAX_DEPTH];
	logic             token_valid_q;
	token_t           token_q;

	logic             can_emit;
	logic             has_open;
	logic [IDX_W-1:0] top_idx;
	logic [32:0]      top_ext;
	logic [32:0]      nxt_inc;
	logic [31:0]      new_acc;
	logic             len_ovf;
	logic             start_list;
	logic [31:0]      start_len;
	logic [32:0]      end_sum;
	logic             room_bad;
	logic             emit;
	logic             push;
	logic             ends;
	logic             trunc;
	logic             clear;
	logic             done;
	logic             cond0;
	logic             do_start;
	logic             do_finish;
	logic             do_header;
	logic             fail_now;
	err_t             fail_code;
	token_t           res;

	assign can_emit   = !token_valid_q || !token_stall;
	assign has_open   = (open_q != '0);
	assign top_idx    = IDX_W'(open_q - CNT_W'(1));
	assign top_ext    = {1'b0, stack_q[top_idx]};
	assign nxt_inc    = {1'b0, nxt_q[31:0]} + 33'd1;
	assign new_acc    = {acc_q[23:0], head.item.byte_in};
	assign len_ovf    = ((acc_q >> (LBITS - 8)) != '0);
	assign start_list = (phase_q == PH_LENB) ? is_list_q : (head.cls == CLS_SHORT_LIST);
	assign start_len  = (phase_q == PH_LENB) ? new_acc : 32'(head.short_len);
	assign end_sum    = nxt_q + {1'b0, start_len};
	assign room_bad   = has_open && (nxt_q >= top_ext);

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		code_d    = code_q;
		left_d    = left_q;
		acc_d     = acc_q;
		is_list_d = is_list_q;
		nxt_d     = nxt_q;
		end_pos_d = end_pos_q;
		str_end_d = str_end_q;
		open_d    = open_q;
		emit      = 1'b0;
		push      = 1'b0;
		ends      = 1'b0;
		trunc     = 1'b0;
		clear     = 1'b0;
		done      = 1'b0;
		cond0     = 1'b0;
		do_start  = 1'b0;
		do_finish = 1'b0;
		do_header = 1'b0;
		fail_now  = 1'b0;
		fail_code = ERR_NONE;
		head_pop  = 1'b0;
		res       = '0;
		res.depth = 5'(open_q);

		unique case (state_q)
			S_MAIN: begin
				if (head_valid && can_emit) begin
					emit = 1'b1;
					unique case (phase_q)
						PH_DONE: begin
							res.kind = KIND_IGNORED;
							ends     = 1'b1;
						end
						PH_FAIL: begin
							res.kind       = KIND_IGNORED;
							res.error_code = code_q;
							ends           = 1'b1;
						end
						PH_PREFIX: begin
							nxt_d = nxt_inc;
							unique case (head.cls) inside
								CLS_SINGLE: begin
									res.kind      = KIND_SINGLE;
									res.data_byte = head.item.byte_in;
									do_finish     = 1'b1;
								end
								CLS_SHORT_STR, CLS_SHORT_LIST: begin
									do_start = 1'b1;
								end
								CLS_LONG_STR, CLS_LONG_LIST: begin
									do_header = 1'b1;
									is_list_d = (head.cls == CLS_LONG_LIST);
									left_d    = head.len_bytes;
									acc_d     = '0;
									phase_d   = PH_LENB;
								end
								default: begin
									ends = 1'b1;
								end
							endcase
						end
						PH_LENB: begin
							nxt_d = nxt_inc;
							if (len_ovf) begin
								fail_now  = 1'b1;
								fail_code = ERR_LENGTH;
							end else begin
								acc_d  = new_acc;
								left_d = left_q - 4'd1;
								if (left_q != 4'd1) begin
									do_header = 1'b1;
								end else begin
									do_start = 1'b1;
								end
							end
						end
						PH_DATA: begin
							nxt_d         = nxt_inc;
							res.kind      = KIND_DATA;
							res.data_byte = head.item.byte_in;
							if (nxt_q == {1'b0, str_end_q}) begin
								do_finish = 1'b1;
							end else begin
								ends = 1'b1;
							end
						end
						default: begin
							ends = 1'b1;
						end
					endcase

					if (do_header) begin
						res.kind = KIND_HEADER;
						if (room_bad) begin
							state_d = S_ERR;
						end else begin
							ends = 1'b1;
						end
					end

					if (do_start) begin
						if (end_sum[32]) begin
							fail_now  = 1'b1;
							fail_code = ERR_LENGTH;
						end else if (has_open && (end_sum > top_ext)) begin
							fail_now  = 1'b1;
							fail_code = ERR_OVERRUN;
						end else if (start_list && (open_q >= CNT_W'(MAX_DEPTH))) begin
							fail_now  = 1'b1;
							fail_code = ERR_DEEP;
						end else begin
							res.kind        = start_list ? KIND_LIST_START : KIND_STR_START;
							res.item_length = start_len;
							if (start_list) begin
								push      = 1'b1;
								open_d    = open_q + CNT_W'(1);
								res.depth = 5'(open_q + CNT_W'(1));
							end
							if (start_len == '0) begin
								do_finish = 1'b1;
							end else begin
								phase_d = start_list ? PH_PREFIX : PH_DATA;
								if (!start_list) begin
									str_end_d = end_sum[31:0];
								end
								ends = 1'b1;
							end
						end
					end

					if (do_finish) begin
						// an empty list always closes itself
						cond0 = (do_start && start_list) || (has_open && (top_ext == nxt_q));
						if (cond0) begin
							end_pos_d = nxt_q;
							state_d   = S_LOOK;
						end else begin
							done          = (open_d == '0);
							phase_d       = done ? PH_DONE : PH_PREFIX;
							res.item_done = done;
							ends          = 1'b1;
						end
					end

					if (fail_now) begin
						res            = '0;
						res.kind       = KIND_ERROR;
						res.error_code = fail_code;
						res.depth      = 5'(open_q);
						phase_d        = PH_FAIL;
						code_d         = fail_code;
						ends           = 1'b1;
					end
				end
			end
			S_LOOK: begin
				open_d  = open_q - CNT_W'(1);
				state_d = S_CLOSE;
			end
			S_CLOSE: begin
				if (can_emit) begin
					emit     = 1'b1;
					res.kind = KIND_LIST_END;
					if (has_open && (top_ext == end_pos_q)) begin
						state_d = S_LOOK;
					end else begin
						done          = !has_open;
						phase_d       = done ? PH_DONE : PH_PREFIX;
						res.item_done = done;
						ends          = 1'b1;
					end
				end
			end
			S_ERR: begin
				if (can_emit) begin
					emit           = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_OVERRUN;
					phase_d        = PH_FAIL;
					code_d         = ERR_OVERRUN;
					ends           = 1'b1;
				end
			end
			S_TRUNC: begin
				if (can_emit) begin
					emit           = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_TRUNC;
					phase_d        = PH_FAIL;
					code_d         = ERR_TRUNC;
					ends           = 1'b1;
				end
			end
			default: begin
				state_d = S_MAIN;
			end
		endcase

		// append a truncation error when the message stops mid-item
		if (ends) begin
			trunc = head.item.last_byte &&
				(phase_d == PH_PREFIX || phase_d == PH_LENB || phase_d == PH_DATA);
			if (trunc) begin
				state_d = S_TRUNC;
			end else begin
				res.last_of_run = 1'b1;
				head_pop        = 1'b1;
				state_d         = S_MAIN;
				clear           = head.item.last_byte;
			end
		end

		if (clear) begin
			phase_d   = PH_PREFIX;
			code_d    = ERR_NONE;
			left_d    = '0;
			acc_d     = '0;
			is_list_d = 1'b0;
			nxt_d     = 33'd1;
			str_end_d = '0;
			open_d    = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			stack_q[IDX_W'(open_q)] <= end_sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_MAIN;
			phase_q       <= PH_PREFIX;
			code_q        <= ERR_NONE;
			left_q        <= '0;
			acc_q         <= '0;
			is_list_q     <= 1'b0;
			nxt_q         <= 33'd1;
			end_pos_q     <= '0;
			str_end_q     <= '0;
			open_q        <= '0;
			token_valid_q <= 1'b0;
			token_q       <= '0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			code_q    <= code_d;
			left_q    <= left_d;
			acc_q     <= acc_d;
			is_list_q <= is_list_d;
			nxt_q     <= nxt_d;
			end_pos_q <= end_pos_d;
			str_end_q <= str_end_d;
			open_q    <= open_d;
			if (emit) begin
				token_valid_q <= 1'b1;
				token_q       <= res;
			end else if (!token_stall) begin
				token_valid_q <= 1'b0;
			end
		end
	end

	assign token_valid = token_valid_q;
	assign token       = token_q;

endmodule

`default_nettype wire

// ----- rtl/rlp_stream_decoder_top.sv -----
`default_nettype none

// RLP stream decoder. Feed one message byte per request on the byte channel,
// with last_byte set on the final byte of the buffer; tokens come out on the
// token channel, one per request, the last token of each byte flagged with
// last_of_run. A two-entry queue sits between the byte classifier and the
// decoding sequencer, and the token output is registered, so bytes still enter
// the queue while it has room and a token waits. A byte that closes nested
// lists passes a look state and a close state for each list, since each close
// reads the top of the list-end stack before the next compare; a header that
// overruns its parent and a truncation error each add a state that emits the
// error. After last_byte the decoder is back in its reset state for the next
// message. Nesting is limited to 16 open lists and lengths to 32 bits.
module rlp_stream_decoder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  rsd_pkg::byte_item_t byte_data,
	output logic                token_valid,
	input  logic                token_stall,
	output rsd_pkg::token_t     token
);
	import rsd_pkg::*;

	logic   head_valid;
	entry_t head;
	logic   head_pop;

	rsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop)
	);

	rsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.head_pop    (head_pop),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token       (token)
	);

	// a completed top item leaves nothing to append for that byte
	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token.item_done |-> token.last_of_run)
		else $error("item_done without last_of_run");

	a_error_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token.kind == KIND_ERROR) |->
			(token.error_code != ERR_NONE) && token.last_of_run
			|| (token.error_code == ERR_OVERRUN) || (token.error_code == ERR_LENGTH)
			|| (token.error_code == ERR_DEEP))
		else $error("error token without a code");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> (token.depth <= 5'(MAX_DEPTH)))
		else $error("depth beyond nesting limit");

	a_pop_only_head: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> head_valid)
		else $error("queue popped while empty");

endmodule

`default_nettype wire
